// File: rtl/zrd_pkg.sv
// ----------------------------------------------------------------------------
// zrd_pkg
// shared types, codes and the header crc step for the zmodem receive deframer
// ----------------------------------------------------------------------------
`default_nettype none

package zrd_pkg;

	// default configuration
	localparam int unsigned MAX_DATA_DEF  = 1024;
	localparam int unsigned MID_DEPTH_DEF = 4;
	localparam int unsigned OUT_DEPTH_DEF = 2;

	// framing bytes
	localparam logic [7:0] PAD_BYTE  = 8'h2A;  // '*'
	localparam logic [7:0] ZDLE_BYTE = 8'h18;
	localparam logic [7:0] END_CRCE  = 8'h68;  // 'h'
	localparam logic [7:0] END_CRCG  = 8'h69;  // 'i'
	localparam logic [7:0] END_CRCQ  = 8'h6A;  // 'j'
	localparam logic [7:0] END_CRCW  = 8'h6B;  // 'k'
	localparam logic [7:0] ESC_XOR   = 8'h40;

	// frame types that carry a data subpacket
	localparam logic [7:0] FT_ZFILE = 8'd4;
	localparam logic [7:0] FT_ZDATA = 8'd10;

	// crc-16 settings
	localparam logic [15:0] CRC_POLY = 16'h1021;
	localparam logic [15:0] CRC_INIT = 16'hFFFF;

	localparam int unsigned COUNT_OUT_W = 11;

	typedef enum logic [1:0] {
		EV_HEADER = 2'd0,
		EV_DATA   = 2'd1,
		EV_END    = 2'd2
	} event_kind_t;

	typedef enum logic [2:0] {
		ST_HUNT,
		ST_TYPE,
		ST_HDR,
		ST_CRCHI,
		ST_CRCLO,
		ST_DATA
	} parse_state_t;

	// byte after classification by the front end
	typedef struct packed {
		logic [7:0] raw;
		logic [7:0] unesc;
		logic       is_pad;
		logic       is_dle;
		logic       is_end;
	} rx_item_t;

	// one result item
	typedef struct packed {
		event_kind_t            event_kind;
		logic [7:0]             frame_type;
		logic                   crc_ok;
		logic [7:0]             data_byte;
		logic                   is_last;
		logic [COUNT_OUT_W-1:0] byte_count;
	} result_t;

	// one byte of crc-16, msb first
	function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

`default_nettype wire

// File: rtl/zrd_fifo.sv
// ----------------------------------------------------------------------------
// zrd_fifo
// small register queue with push/full and pop/empty sides
// ----------------------------------------------------------------------------
`default_nettype none

module zrd_fifo #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wdata,
	output logic                  full,
	input  wire logic             pop,
	output logic [WIDTH-1:0]      rdata,
	output logic                  empty
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wptr_q, rptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= (wptr_q == PTR_W'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == PTR_W'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// File: rtl/zrd_front.sv
// ----------------------------------------------------------------------------
// zrd_front
// classifies each received byte for the parser
// ----------------------------------------------------------------------------
`default_nettype none

module zrd_front
	import zrd_pkg::*;
(
	input  wire logic [7:0] rx_byte,
	output rx_item_t        item
);

	always_comb begin
		item.raw    = rx_byte;
		item.unesc  = rx_byte ^ ESC_XOR;
		item.is_pad = (rx_byte == PAD_BYTE);
		item.is_dle = (rx_byte == ZDLE_BYTE);
		item.is_end = (rx_byte == END_CRCE) || (rx_byte == END_CRCG) ||
		              (rx_byte == END_CRCQ) || (rx_byte == END_CRCW);
	end

endmodule

`default_nettype wire

// File: rtl/zrd_back.sv
// ----------------------------------------------------------------------------
// zrd_back
// header and subpacket parser, one classified byte per cycle while the result queue has room
// ----------------------------------------------------------------------------
`default_nettype none

module zrd_back
	import zrd_pkg::*;
#(
	parameter int unsigned MAX_DATA = MAX_DATA_DEF
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	input  wire rx_item_t in_item,
	output logic          in_ready,
	output logic          res_push,
	output result_t       res,
	input  wire logic     res_full
);

	localparam int unsigned CNT_W = $clog2(MAX_DATA + 1);

	parse_state_t     state_q, state_d;
	logic [1:0]       hdr_idx_q;
	logic [15:0]      crc_q;
	logic [7:0]       crc_hi_q;
	logic [7:0]       type_q;
	logic             esc_q;
	logic [CNT_W-1:0] count_q;

	logic             take;
	logic [CNT_W-1:0] count_inc;
	logic             hit_max;
	logic             crc_match;
	logic             data_type;
	logic [7:0]       data_val;
	logic [CNT_W+COUNT_OUT_W-1:0] cnt_ext;

	assign in_ready  = !res_full;
	assign take      = in_valid && in_ready;
	assign count_inc = count_q + 1'b1;
	assign hit_max   = (count_inc == CNT_W'(MAX_DATA));
	assign crc_match = ({crc_hi_q, in_item.raw} == crc_q);
	assign data_type = (type_q == FT_ZFILE) || (type_q == FT_ZDATA);
	assign data_val  = esc_q ? in_item.unesc : in_item.raw;

	// next state
	always_comb begin
		state_d = state_q;
		if (take) begin
			unique case (state_q)
				ST_HUNT:  if (in_item.is_pad) state_d = ST_TYPE;
				ST_TYPE:  state_d = ST_HDR;
				ST_HDR:   if (hdr_idx_q == 2'd3) state_d = ST_CRCHI;
				ST_CRCHI: state_d = ST_CRCLO;
				ST_CRCLO: state_d = (crc_match && data_type) ? ST_DATA : ST_HUNT;
				ST_DATA: begin
					priority if (in_item.is_dle) begin
						state_d = ST_DATA;
					end else if (esc_q && in_item.is_end) begin
						state_d = ST_HUNT;
					end else if (hit_max) begin
						state_d = ST_HUNT;
					end else begin
						state_d = ST_DATA;
					end
				end
				default:  state_d = ST_HUNT;
			endcase
		end
	end

	// result outputs
	always_comb begin
		res_push       = 1'b0;
		res.event_kind = EV_HEADER;
		res.frame_type = type_q;
		res.crc_ok     = 1'b0;
		res.data_byte  = 8'h00;
		res.is_last    = 1'b0;
		cnt_ext        = '0;
		unique case (state_q)
			ST_CRCLO: begin
				res_push   = take;
				res.crc_ok = crc_match;
			end
			ST_DATA: begin
				priority if (in_item.is_dle) begin
					res_push = 1'b0;
				end else if (esc_q && in_item.is_end) begin
					res_push       = take;
					res.event_kind = EV_END;
					res.data_byte  = in_item.raw;
					cnt_ext        = (CNT_W + COUNT_OUT_W)'(count_q);
				end else begin
					res_push       = take;
					res.event_kind = EV_DATA;
					res.data_byte  = data_val;
					res.is_last    = hit_max;
					cnt_ext        = (CNT_W + COUNT_OUT_W)'(count_inc);
				end
			end
			default: res_push = 1'b0;
		endcase
		res.byte_count = cnt_ext[COUNT_OUT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_HUNT;
			hdr_idx_q <= '0;
			crc_q     <= CRC_INIT;
			crc_hi_q  <= '0;
			type_q    <= '0;
			esc_q     <= 1'b0;
			count_q   <= '0;
		end else begin
			state_q <= state_d;
			if (take) begin
				unique case (state_q)
					ST_TYPE: begin
						type_q    <= in_item.raw;
						hdr_idx_q <= '0;
						crc_q     <= CRC_INIT;
					end
					ST_HDR: begin
						crc_q     <= crc_feed(crc_q, in_item.raw);
						hdr_idx_q <= hdr_idx_q + 1'b1;
					end
					ST_CRCHI: crc_hi_q <= in_item.raw;
					ST_CRCLO: begin
						esc_q   <= 1'b0;
						count_q <= '0;
					end
					ST_DATA: begin
						if (in_item.is_dle) begin
							esc_q <= 1'b1;
						end else begin
							esc_q <= 1'b0;
							if (!(esc_q && in_item.is_end)) begin
								count_q <= count_inc;
							end
						end
					end
					default: ;
				endcase
			end
		end
	end

	// a result only comes from a byte taken in the same cycle
	a_push_needs_take: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> take)
		else $error("result pushed without a byte transfer");

	// the last flag belongs to data events only
	a_last_only_data: assert property (@(posedge clk) disable iff (!arst_n)
		(res_push && res.event_kind != EV_DATA) |-> !res.is_last)
		else $error("is_last set on a non-data event");

	// a header with a bad crc never opens a subpacket
	a_bad_crc_hunts: assert property (@(posedge clk) disable iff (!arst_n)
		(res_push && res.event_kind == EV_HEADER && !res.crc_ok) |=> state_q == ST_HUNT)
		else $error("bad header crc did not return to hunting");

	// a last data byte closes the subpacket
	a_last_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(res_push && res.is_last) |=> state_q == ST_HUNT)
		else $error("subpacket still open after last byte");

endmodule

`default_nettype wire

// File: rtl/zmodem_receive_deframer_top.sv
// ----------------------------------------------------------------------------
// zmodem_receive_deframer_top
// zmodem receive side header and data subpacket deframer
// ----------------------------------------------------------------------------
// Push received serial bytes in on rx_byte (push/full) and pop events out
// (empty/pop). The block hunts for '*', takes the frame type, four header
// bytes and two crc bytes high first, and reports one header event with the
// type and a crc check (crc-16 poly 0x1021, init 0xffff, over the four header
// bytes only). A good header of type 4 or 10 opens a data subpacket: every
// payload byte is reported unescaped with its running count; zdle followed by
// h, i, j or k ends it with an end event, and the MAX_DATA-th byte ends it
// with is_last set. A new byte is accepted each clock while the middle
// queue has room, and the parser retires one queued byte each clock while
// the result queue has room, so the sustained rate is one byte per cycle
// when the consumer pops every cycle. A byte is registered in the middle
// queue and its event in the result queue before the event shows on the
// result ports. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module zmodem_receive_deframer_top
	import zrd_pkg::*;
#(
	parameter int unsigned MAX_DATA  = MAX_DATA_DEF,
	parameter int unsigned MID_DEPTH = MID_DEPTH_DEF,
	parameter int unsigned OUT_DEPTH = OUT_DEPTH_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	// input side, a transfer is push && !full
	input  wire logic                   push,
	output logic                        full,
	input  wire logic [7:0]             rx_byte,
	// result side, a transfer is pop && !empty
	output logic                        empty,
	input  wire logic                   pop,
	output logic [1:0]                  event_kind,
	output logic [7:0]                  frame_type,
	output logic                        crc_ok,
	output logic [7:0]                  data_byte,
	output logic                        is_last,
	output logic [COUNT_OUT_W-1:0]      byte_count
);

	localparam int unsigned ITEM_W = $bits(rx_item_t);
	localparam int unsigned RES_W  = $bits(result_t);

	rx_item_t front_item;   // classified byte from the front end
	rx_item_t mid_item;     // head of the middle queue
	logic     mid_empty;
	logic     back_ready;
	logic     res_push;
	logic     res_full;
	result_t  back_res;     // event produced by the parser
	result_t  out_res;      // oldest waiting event

	// front end: classify each byte as it arrives
	zrd_front u_front (
		.rx_byte (rx_byte),
		.item    (front_item)
	);

	// middle queue decouples byte arrival from the parser
	zrd_fifo #(
		.WIDTH (ITEM_W),
		.DEPTH (MID_DEPTH)
	) u_mid_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (front_item),
		.full   (full),
		.pop    (back_ready),
		.rdata  (mid_item),
		.empty  (mid_empty)
	);

	// back end: parser state machine, stalls only on a full result queue
	zrd_back #(
		.MAX_DATA (MAX_DATA)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (!mid_empty),
		.in_item  (mid_item),
		.in_ready (back_ready),
		.res_push (res_push),
		.res      (back_res),
		.res_full (res_full)
	);

	// result queue holds finished events until popped
	zrd_fifo #(
		.WIDTH (RES_W),
		.DEPTH (OUT_DEPTH)
	) u_out_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (back_res),
		.full   (res_full),
		.pop    (pop),
		.rdata  (out_res),
		.empty  (empty)
	);

	assign event_kind = out_res.event_kind;
	assign frame_type = out_res.frame_type;
	assign crc_ok     = out_res.crc_ok;
	assign data_byte  = out_res.data_byte;
	assign is_last    = out_res.is_last;
	assign byte_count = out_res.byte_count;

endmodule

`default_nettype wire
